// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check outside reset only.
`define RWS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check at every edge, reset included.
`define RWS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== src/rws_pkg.sv =====
// Types and constants for the roulette wheel selection block.
// No dependencies.
package rws_pkg;

  localparam int FIT_W   = 16;
  localparam int SPIN_W  = 16;
  localparam int SUM_W   = 22;
  localparam int BOUND_W = SUM_W + SPIN_W;
  localparam int MIDX_W  = 6;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_SPIN = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [FIT_W-1:0]  fitness;
    logic [SPIN_W-1:0] spin;
  } in_beat_t;

  typedef struct packed {
    logic [MIDX_W-1:0] member_index;
    logic              elite_pick;
  } out_beat_t;

  // Control bits of the query walking down the row of cells.
  typedef struct packed {
    logic valid;
    logic elite;
    logic found;
  } query_ctl_t;

endpackage

// ===== src/rws_cell.sv =====
// One cell of the selection row: holds one member's prefix sum and checks the
// passing query against it. Depends on rws_pkg.
module rws_cell #(
  parameter int IDX = 0,
  parameter int IW  = 6,
  parameter int CW  = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        wr_en,
  input  logic [IW-1:0]               wr_idx,
  input  logic [rws_pkg::SUM_W-1:0]   wr_sum,
  input  logic [CW-1:0]               count,
  input  rws_pkg::query_ctl_t         q_ctl_in,
  input  logic [rws_pkg::BOUND_W-1:0] q_bound_in,
  input  logic [IW-1:0]               q_idx_in,
  output rws_pkg::query_ctl_t         q_ctl_out,
  output logic [rws_pkg::BOUND_W-1:0] q_bound_out,
  output logic [IW-1:0]               q_idx_out
);

  logic [rws_pkg::SUM_W-1:0]   sum_r;
  rws_pkg::query_ctl_t         ctl_r, ctl_nxt;
  logic [rws_pkg::BOUND_W-1:0] bound_r;
  logic [IW-1:0]               idx_r, idx_nxt;
  logic                        live;
  logic                        hit;

  assign live = count > CW'(IDX);
  assign hit  = q_ctl_in.valid && !q_ctl_in.elite && !q_ctl_in.found && live &&
                ({sum_r, {rws_pkg::SPIN_W{1'b0}}} >= q_bound_in);

  always_comb begin
    ctl_nxt       = q_ctl_in;
    ctl_nxt.found = q_ctl_in.found | hit;
    idx_nxt       = hit ? IW'(IDX) : q_idx_in;
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == IW'(IDX))) begin
      sum_r <= wr_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bound_r <= q_bound_in;
      idx_r   <= idx_nxt;
    end
  end

  assign q_ctl_out   = ctl_r;
  assign q_bound_out = bound_r;
  assign q_idx_out   = idx_r;

endmodule

// ===== src/roulette_wheel_selection.sv =====
// Fitness-proportional (roulette wheel) selection. A load beat appends one
// fitness as the next member's running prefix sum in a row of POP_DEPTH cells;
// loads past POP_DEPTH members are dropped, and the first load after a spin
// starts a new population. A spin beat registers the bound spin * total and
// sends it down the row, one cell per cycle unless the row is held; the first
// live cell whose prefix sum times 2^16 meets the bound claims it. in_ready
// returns in the same cycle as the result appears, so no new spin is taken
// while one is in the row, and the row is held while the result register is
// held by out_ready. A zero total or an empty population returns elite_pick
// with member_index 0.
// Depends on rws_pkg and rws_cell.
module roulette_wheel_selection #(
  parameter int POP_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rws_pkg::in_beat_t in_beat,
  output logic              out_valid,
  input  logic              out_ready,
  output rws_pkg::out_beat_t out_beat
);

  localparam int IW = (POP_DEPTH > 1) ? $clog2(POP_DEPTH) : 1;
  localparam int CW = $clog2(POP_DEPTH + 1);

  logic                        busy_r, busy_nxt;
  logic                        spun_r, spun_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [rws_pkg::SUM_W-1:0]   total_r, total_nxt;
  rws_pkg::query_ctl_t         launch_ctl_r, launch_ctl_nxt;
  logic [rws_pkg::BOUND_W-1:0] launch_bound_r;
  logic                        out_valid_r, out_valid_nxt;
  rws_pkg::out_beat_t          out_beat_r;

  logic                        acc, load_acc, spin_acc, adv, tail_take;
  logic [CW-1:0]               base_count;
  logic [rws_pkg::SUM_W-1:0]   base_total;
  logic [rws_pkg::SUM_W:0]     sum_wide;
  logic [rws_pkg::SUM_W-1:0]   sum_sat;
  logic                        wr_en;

  rws_pkg::query_ctl_t         q_ctl   [POP_DEPTH+1];
  logic [rws_pkg::BOUND_W-1:0] q_bound [POP_DEPTH+1];
  logic [IW-1:0]               q_idx   [POP_DEPTH+1];

  assign in_ready  = !busy_r;
  assign acc       = in_valid && in_ready;
  assign load_acc  = acc && (in_beat.op == rws_pkg::OP_LOAD);
  assign spin_acc  = acc && (in_beat.op == rws_pkg::OP_SPIN);

  // Hold the whole row while a query waits at the tail and the result register is full and stalled.
  assign adv       = !(q_ctl[POP_DEPTH].valid && out_valid_r && !out_ready);
  assign tail_take = q_ctl[POP_DEPTH].valid && adv;

  assign base_count = spun_r ? '0 : count_r;
  assign base_total = spun_r ? '0 : total_r;
  assign sum_wide   = {1'b0, base_total} + (rws_pkg::SUM_W+1)'(in_beat.fitness);
  assign sum_sat    = sum_wide[rws_pkg::SUM_W] ? rws_pkg::SUM_MAX
                                               : sum_wide[rws_pkg::SUM_W-1:0];
  assign wr_en      = load_acc && (base_count < CW'(POP_DEPTH));

  always_comb begin
    count_nxt = count_r;
    total_nxt = total_r;
    spun_nxt  = spun_r;
    busy_nxt  = busy_r;
    if (load_acc) begin
      spun_nxt  = 1'b0;
      count_nxt = base_count;
      total_nxt = base_total;
      if (wr_en) begin
        count_nxt = base_count + CW'(1);
        total_nxt = sum_sat;
      end
    end
    if (spin_acc) begin
      spun_nxt = 1'b1;
      busy_nxt = 1'b1;
    end else if (tail_take) begin
      busy_nxt = 1'b0;
    end
  end

  always_comb begin
    launch_ctl_nxt = launch_ctl_r;
    if (spin_acc) begin
      launch_ctl_nxt.valid = 1'b1;
      launch_ctl_nxt.elite = (total_r == '0) || (count_r == '0);
      launch_ctl_nxt.found = 1'b0;
    end else if (adv) begin
      launch_ctl_nxt = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (tail_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      spun_r       <= 1'b0;
      count_r      <= '0;
      total_r      <= '0;
      launch_ctl_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      spun_r       <= spun_nxt;
      count_r      <= count_nxt;
      total_r      <= total_nxt;
      launch_ctl_r <= launch_ctl_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (spin_acc) begin
      launch_bound_r <= rws_pkg::BOUND_W'(in_beat.spin) * rws_pkg::BOUND_W'(total_r);
    end
    if (tail_take) begin
      out_beat_r.elite_pick   <= q_ctl[POP_DEPTH].elite;
      out_beat_r.member_index <= q_ctl[POP_DEPTH].elite ? '0
                                 : rws_pkg::MIDX_W'(q_idx[POP_DEPTH]);
    end
  end

  assign q_ctl[0]   = launch_ctl_r;
  assign q_bound[0] = launch_bound_r;
  assign q_idx[0]   = '0;

  for (genvar i = 0; i < POP_DEPTH; i++) begin : g_cell
    rws_cell #(
      .IDX (i),
      .IW  (IW),
      .CW  (CW)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .adv         (adv),
      .wr_en       (wr_en),
      .wr_idx      (base_count[IW-1:0]),
      .wr_sum      (sum_sat),
      .count       (count_r),
      .q_ctl_in    (q_ctl[i]),
      .q_bound_in  (q_bound[i]),
      .q_idx_in    (q_idx[i]),
      .q_ctl_out   (q_ctl[i+1]),
      .q_bound_out (q_bound[i+1]),
      .q_idx_out   (q_idx[i+1])
    );
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

// ===== src/rws_checker.sv =====
// Port-level checks for roulette_wheel_selection, bound to the top level.
// Depends on rws_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rws_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input rws_pkg::in_beat_t  in_beat,
  input logic               out_valid,
  input logic               out_ready,
  input rws_pkg::out_beat_t out_beat
);

  `RWS_ASSERT_ALWAYS(a_no_out_after_reset, !rst_n |=> !out_valid)
  `RWS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_beat))
  `RWS_ASSERT(a_elite_index_zero, out_valid && out_beat.elite_pick |-> out_beat.member_index == '0)
  `RWS_ASSERT(a_spin_blocks_input, in_valid && in_ready && in_beat.op == rws_pkg::OP_SPIN |=> !in_ready)

endmodule

bind roulette_wheel_selection rws_checker u_rws_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_beat   (in_beat),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_beat  (out_beat)
);
